FILE: sv/gregorian_julian_day_converter_top_assert.svh
// Assertion macros for the Gregorian / Julian day converter.
`ifndef GREGORIAN_JULIAN_DAY_CONVERTER_TOP_ASSERT_SVH
`define GREGORIAN_JULIAN_DAY_CONVERTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GJD_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("gjd: assertion failed");
`define GJD_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("gjd: forbidden condition seen");
`else
`define GJD_ASSERT(name, clk, rstn, prop)
`define GJD_NEVER(name, clk, rstn, expr)
`endif
`endif

FILE: sv/gjd_pkg.sv
// Types, constants and calendar tables for the Gregorian / Julian day converter.
package gjd_pkg;

  typedef enum logic {
    ACT_TO_JDN  = 1'b0,
    ACT_TO_DATE = 1'b1
  } gjd_action_e;

  typedef struct packed {
    logic        action;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [22:0] day_number_in;
  } gjd_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [22:0] day_number_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic        leap_year;
  } gjd_res_t;

  localparam logic [22:0] JDN_BASE = 23'd1721119;
  localparam logic [22:0] JDN_MIN  = 23'd1721120;
  localparam logic [22:0] JDN_MAX  = 23'd5373484;

  localparam logic [13:0] YEAR_LOW = 14'd100;
  localparam logic [13:0] YEAR_OFS = 14'd1900;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // constant divisors: quotient = (n * K) >> SH, exact over the operand range
  localparam logic [17:0] CENT_D  = 18'd146097;
  localparam int          CENT_SH = 43;
  localparam logic [25:0] CENT_K  =
      26'(((64'd1 << CENT_SH) + 64'(CENT_D) - 64'd1) / 64'(CENT_D));

  localparam logic [10:0] YA_D  = 11'd1461;
  localparam int          YA_SH = 29;
  localparam logic [18:0] YA_K  =
      19'(((64'd1 << YA_SH) + 64'(YA_D) - 64'd1) / 64'(YA_D));

  localparam logic [7:0]  M_D  = 8'd153;
  localparam int          M_SH = 19;
  localparam logic [11:0] M_K  =
      12'(((64'd1 << M_SH) + 64'(M_D) - 64'd1) / 64'(M_D));

  localparam logic [2:0]  DD_D  = 3'd5;
  localparam int          DD_SH = 11;
  localparam logic [8:0]  DD_K  =
      9'(((64'd1 << DD_SH) + 64'(DD_D) - 64'd1) / 64'(DD_D));

  localparam logic [6:0]  Y100_D  = 7'd100;
  localparam int          Y100_SH = 21;
  localparam logic [14:0] Y100_K  =
      15'(((64'd1 << Y100_SH) + 64'(Y100_D) - 64'd1) / 64'(Y100_D));

  localparam logic [2:0]  W7_D  = 3'd7;
  localparam int          W7_SH = 26;
  localparam logic [23:0] W7_K  =
      24'(((64'd1 << W7_SH) + 64'(W7_D) - 64'd1) / 64'(W7_D));

  // days in month, February without leap day
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // days before month, non-leap year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // days before month in a March-based year: (153 * mm + 2) / 5
  function automatic logic [8:0] mar_offset(input logic [3:0] mm);
    logic [8:0] r;
    unique case (mm)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/gjd_if.sv
// Valid/ready stream interfaces for converter requests and results.
interface gjd_in_if;
  logic              valid;
  logic              ready;
  gjd_pkg::gjd_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gjd_out_if;
  logic              valid;
  logic              ready;
  gjd_pkg::gjd_res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/gregorian_julian_day_converter_top.sv
// Gregorian date / Julian day number converter, seven-stage pipeline.
// Throughput: one item per cycle while the output is not stalled; the constant-divisor multiplies are staged.
// A stalled output freezes only the full stages behind it; bubbles still fill.
// Reset (async, active low) clears the stage valid bits; payload is not reset.
`include "gregorian_julian_day_converter_top_assert.svh"

module gregorian_julian_day_converter_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  gjd_in_if.sink    in_i,
  gjd_out_if.source out_o
);

  localparam int NumStages = 7;

  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   en;

  always_comb begin
    en[NumStages] = out_o.ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_i.ready = en[0];

  // ---------------- stage A: range checks, first reciprocal products
  gjd_pkg::gjd_in_t din;
  logic [13:0] y_adj, yy;
  logic [3:0]  mm;
  logic        early, bad_a, ok_a;
  logic [21:0] j_a;
  logic [23:0] t_a;

  logic        a_act_q, a_bad_q, a_ok_q;
  logic [3:0]  a_m_q, a_mm_q;
  logic [4:0]  a_d_q;
  logic [13:0] a_yy_q, a_y_q;
  logic [28:0] a_pyy_q, a_py_q;
  logic [22:0] a_jn_q;
  logic [23:0] a_t_q;
  logic [49:0] a_pc_q;
  logic [46:0] a_pw_q;

  always_comb begin
    din   = in_i.data;
    y_adj = (din.year_in < gjd_pkg::YEAR_LOW) ? din.year_in + gjd_pkg::YEAR_OFS
                                              : din.year_in;
    bad_a = (y_adj > gjd_pkg::YEAR_MAX) || (din.day_in == 5'd0) ||
            (din.month_in == 4'd0) || (din.month_in > gjd_pkg::MONTH_DEC);
    early = din.month_in <= gjd_pkg::MONTH_FEB;
    mm    = early ? din.month_in + 4'd9 : din.month_in - 4'd3;
    yy    = early ? y_adj - 14'd1 : y_adj;
    ok_a  = (din.day_number_in >= gjd_pkg::JDN_MIN) &&
            (din.day_number_in <= gjd_pkg::JDN_MAX);
    j_a   = 22'(din.day_number_in - gjd_pkg::JDN_BASE);
    t_a   = {j_a, 2'b00} - 24'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_act_q <= din.action;
      a_bad_q <= bad_a;
      a_m_q   <= din.month_in;
      a_d_q   <= din.day_in;
      a_mm_q  <= mm;
      a_yy_q  <= yy;
      a_y_q   <= y_adj;
      a_pyy_q <= 29'(yy) * 29'(gjd_pkg::Y100_K);
      a_py_q  <= 29'(y_adj) * 29'(gjd_pkg::Y100_K);
      a_ok_q  <= ok_a;
      a_jn_q  <= din.day_number_in;
      a_t_q   <= t_a;
      a_pc_q  <= 50'(t_a) * 50'(gjd_pkg::CENT_K);
      a_pw_q  <= 47'(din.day_number_in) * 47'(gjd_pkg::W7_K);
    end
  end

  // ---------------- stage B: century split, leap/month check, weekday
  logic [6:0]  c_b, ya_b, cy_b, ry_b, cent_b;
  logic        leap_b, bad_b;
  logic [4:0]  lim_b;
  logic [17:0] rem_b;
  logic [20:0] q7_b;
  logic [2:0]  r7_b, wd_b;

  logic        b_act_q, b_bad_q, b_ok_q;
  logic [4:0]  b_d_q;
  logic [3:0]  b_mm_q;
  logic [6:0]  b_c_q, b_ya_q, b_cent_q;
  logic [22:0] b_jn_q;
  logic [17:0] b_rem_q;
  logic [2:0]  b_wd_q;

  always_comb begin
    c_b    = a_pyy_q[gjd_pkg::Y100_SH +: 7];
    ya_b   = 7'(a_yy_q - 14'(c_b) * 14'(gjd_pkg::Y100_D));
    cy_b   = a_py_q[gjd_pkg::Y100_SH +: 7];
    ry_b   = 7'(a_y_q - 14'(cy_b) * 14'(gjd_pkg::Y100_D));
    leap_b = (a_y_q[1:0] == 2'b00) && ((ry_b != 7'd0) || (cy_b[1:0] == 2'b00));
    lim_b  = gjd_pkg::month_len(a_m_q) +
             5'((a_m_q == gjd_pkg::MONTH_FEB) && leap_b);
    bad_b  = a_bad_q || (a_d_q > lim_b);
    cent_b = a_pc_q[gjd_pkg::CENT_SH +: 7];
    rem_b  = 18'(a_t_q - 24'(cent_b) * 24'(gjd_pkg::CENT_D));
    q7_b   = a_pw_q[gjd_pkg::W7_SH +: 21];
    r7_b   = 3'(a_jn_q - 23'(q7_b) * 23'(gjd_pkg::W7_D));
    wd_b   = (r7_b == 3'd6) ? 3'd0 : r7_b + 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_act_q  <= a_act_q;
      b_bad_q  <= bad_b;
      b_d_q    <= a_d_q;
      b_mm_q   <= a_mm_q;
      b_c_q    <= c_b;
      b_ya_q   <= ya_b;
      b_ok_q   <= a_ok_q;
      b_jn_q   <= a_jn_q;
      b_cent_q <= cent_b;
      b_rem_q  <= rem_b;
      b_wd_q   <= wd_b;
    end
  end

  // ---------------- stage C: day number terms, year-in-century product
  logic [17:0] u_c;

  logic        c_act_q, c_bad_q, c_ok_q;
  logic [21:0] c_a1_q;
  logic [15:0] c_a2_q;
  logic [8:0]  c_a3_q;
  logic [22:0] c_jn_q;
  logic [6:0]  c_cent_q;
  logic [17:0] c_u_q;
  logic [36:0] c_pya_q;
  logic [2:0]  c_wd_q;

  assign u_c = {b_rem_q[17:2], 2'b11};

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_act_q  <= b_act_q;
      c_bad_q  <= b_bad_q;
      c_a1_q   <= 22'((25'(b_c_q) * 25'(gjd_pkg::CENT_D)) >> 2);
      c_a2_q   <= 16'((18'(b_ya_q) * 18'(gjd_pkg::YA_D)) >> 2);
      c_a3_q   <= gjd_pkg::mar_offset(b_mm_q) + 9'(b_d_q);
      c_ok_q   <= b_ok_q;
      c_jn_q   <= b_jn_q;
      c_cent_q <= b_cent_q;
      c_u_q    <= u_c;
      c_pya_q  <= 37'(u_c) * 37'(gjd_pkg::YA_K);
      c_wd_q   <= b_wd_q;
    end
  end

  // ---------------- stage D: day number sum, day in March-based year
  logic [22:0] j_d;
  logic [6:0]  ya_d;
  logic [10:0] d2_d, v_d;
  logic [8:0]  d3_d;

  logic        d_act_q, d_bad_q, d_ok_q;
  logic [22:0] d_j_q, d_jn_q;
  logic [6:0]  d_cent_q, d_ya_q;
  logic [10:0] d_v_q;
  logic [22:0] d_pm_q;
  logic [2:0]  d_wd_q;

  always_comb begin
    j_d  = 23'(c_a1_q) + 23'(c_a2_q) + 23'(c_a3_q) + gjd_pkg::JDN_BASE;
    ya_d = c_pya_q[gjd_pkg::YA_SH +: 7];
    d2_d = 11'(c_u_q - 18'(ya_d) * 18'(gjd_pkg::YA_D));
    d3_d = 9'((12'(d2_d) + 12'd4) >> 2);
    v_d  = 11'(11'(d3_d) * 11'd5 - 11'd3);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      d_act_q  <= c_act_q;
      d_bad_q  <= c_bad_q;
      d_j_q    <= j_d;
      d_ok_q   <= c_ok_q;
      d_jn_q   <= c_jn_q;
      d_cent_q <= c_cent_q;
      d_ya_q   <= ya_d;
      d_v_q    <= v_d;
      d_pm_q   <= 23'(v_d) * 23'(gjd_pkg::M_K);
      d_wd_q   <= c_wd_q;
    end
  end

  // ---------------- stage E: March-based month and remainder
  logic [3:0] m_e;

  logic        e_act_q, e_bad_q, e_ok_q;
  logic [22:0] e_j_q, e_jn_q;
  logic [6:0]  e_cent_q, e_ya_q;
  logic [3:0]  e_m_q;
  logic [7:0]  e_x_q;
  logic [2:0]  e_wd_q;

  assign m_e = d_pm_q[gjd_pkg::M_SH +: 4];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      e_act_q  <= d_act_q;
      e_bad_q  <= d_bad_q;
      e_j_q    <= d_j_q;
      e_ok_q   <= d_ok_q;
      e_jn_q   <= d_jn_q;
      e_cent_q <= d_cent_q;
      e_ya_q   <= d_ya_q;
      e_m_q    <= m_e;
      e_x_q    <= 8'(d_v_q - 11'(m_e) * 11'(gjd_pkg::M_D));
      e_wd_q   <= d_wd_q;
    end
  end

  // ---------------- stage F: day of month, calendar month, year, leap
  logic [16:0] pdd_f;
  logic [4:0]  dd_f;
  logic        carry_f, roll_f, lp_f;
  logic [3:0]  mo_f;
  logic [6:0]  lo_raw_f, lo_f, hi_f;
  logic [13:0] year_f;

  logic        f_act_q, f_bad_q, f_ok_q, f_lp_q;
  logic [22:0] f_j_q, f_jn_q;
  logic [13:0] f_year_q;
  logic [3:0]  f_mo_q;
  logic [4:0]  f_dd_q;
  logic [2:0]  f_wd_q;

  always_comb begin
    pdd_f    = 17'(e_x_q) * 17'(gjd_pkg::DD_K);
    dd_f     = pdd_f[gjd_pkg::DD_SH +: 5] + 5'd1;
    carry_f  = e_m_q >= 4'd10;
    mo_f     = carry_f ? e_m_q - 4'd9 : e_m_q + 4'd3;
    lo_raw_f = e_ya_q + 7'(carry_f);
    roll_f   = lo_raw_f == 7'(gjd_pkg::Y100_D);
    lo_f     = roll_f ? 7'd0 : lo_raw_f;
    hi_f     = roll_f ? e_cent_q + 7'd1 : e_cent_q;
    year_f   = 14'(14'(hi_f) * 14'(gjd_pkg::Y100_D) + 14'(lo_f));
    lp_f     = (lo_f[1:0] == 2'b00) && ((lo_f != 7'd0) || (hi_f[1:0] == 2'b00));
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      f_act_q  <= e_act_q;
      f_bad_q  <= e_bad_q;
      f_j_q    <= e_j_q;
      f_ok_q   <= e_ok_q;
      f_jn_q   <= e_jn_q;
      f_year_q <= year_f;
      f_mo_q   <= mo_f;
      f_dd_q   <= dd_f;
      f_lp_q   <= lp_f;
      f_wd_q   <= e_wd_q;
    end
  end

  // ---------------- stage G: day of year, result select, output register
  gjd_pkg::gjd_res_t res_g, out_q;
  logic [8:0] doy_g;

  always_comb begin
    doy_g = gjd_pkg::month_start(f_mo_q) + 9'(f_dd_q) - 9'd1 +
            9'(f_lp_q && (f_mo_q > gjd_pkg::MONTH_FEB));
    res_g = '0;
    if (f_act_q == gjd_pkg::ACT_TO_JDN) begin
      if (!f_bad_q) begin
        res_g.valid_res      = 1'b1;
        res_g.day_number_out = f_j_q;
      end
    end else if (f_ok_q) begin
      res_g.valid_res      = 1'b1;
      res_g.day_number_out = f_jn_q;
      res_g.year_out       = f_year_q;
      res_g.month_out      = f_mo_q;
      res_g.day_out        = f_dd_q;
      res_g.weekday        = f_wd_q;
      res_g.day_of_year    = doy_g;
      res_g.leap_year      = f_lp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      out_q <= res_g;
    end
  end

  assign out_o.valid = v_q[NumStages-1];
  assign out_o.data  = out_q;

  // ---------------- assertions
  `GJD_ASSERT(a_invalid_is_zero, clk_i, rst_ni,
    out_o.valid && !out_o.data.valid_res |-> out_o.data.day_number_out == '0 &&
    out_o.data.month_out == '0 && out_o.data.day_out == '0)

  `GJD_ASSERT(a_jdn_in_range, clk_i, rst_ni,
    out_o.valid && out_o.data.valid_res |-> out_o.data.day_number_out >= gjd_pkg::JDN_MIN &&
    out_o.data.day_number_out <= gjd_pkg::JDN_MAX)

  `GJD_ASSERT(a_date_fields_sane, clk_i, rst_ni,
    out_o.valid && out_o.data.month_out != '0 |-> out_o.data.day_out != '0 &&
    out_o.data.month_out <= gjd_pkg::MONTH_DEC && out_o.data.day_of_year <= 9'd365)

  `GJD_NEVER(a_weekday_range, clk_i, rst_ni, out_o.valid && out_o.data.weekday > 3'd6)

  `GJD_ASSERT(a_stall_holds_stage, clk_i, rst_ni,
    v_q[NumStages-2] && !en[NumStages-2] |=> v_q[NumStages-2] && $stable(f_j_q))

endmodule

FILE: verif/testbench.sv
// Testbench for the Gregorian date / Julian day number converter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 500;
  localparam int DRAIN_CYCLES     = 20;
  localparam int MAX_PRINTS       = 100;

  logic clk_i;
  logic rst_ni;

  gjd_in_if  in_if ();
  gjd_out_if out_if ();

  gregorian_julian_day_converter_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  int unsigned mon_days  [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int unsigned mon_first [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  gjd_pkg::gjd_in_t  pend_q [$];
  gjd_pkg::gjd_res_t exp_q  [$];
  int                err_cnt   = 0;
  int                src_idle  = 0;
  int                snk_stall = 0;

  function automatic bit leap_year_of(longint unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // March-based calendar split of a day number (>= JDN_MIN)
  function automatic void jdn_to_civil(input longint unsigned jdn,
                                       output longint unsigned yr,
                                       output longint unsigned mo,
                                       output longint unsigned dy);
    longint unsigned j, cent, r, d, ya, m, y;
    j    = jdn - gjd_pkg::JDN_BASE;
    cent = (j * 4 - 1) / 146097;
    r    = j * 4 - 1 - 146097 * cent;
    d    = r / 4;
    ya   = (d * 4 + 3) / 1461;
    d    = d * 4 + 3 - 1461 * ya;
    d    = (d + 4) / 4;
    m    = (5 * d - 3) / 153;
    d    = 5 * d - 3 - 153 * m;
    dy   = (d + 5) / 5;
    y    = 100 * cent + ya;
    if (m < 10) begin
      m = m + 3;
    end else begin
      m = m - 9;
      y = y + 1;
    end
    yr = y;
    mo = m;
  endfunction

  function automatic gjd_pkg::gjd_res_t predict_conversion(gjd_pkg::gjd_in_t req);
    gjd_pkg::gjd_res_t res;
    longint unsigned   y, m, d, jn, lim, yy, mm, c, ya, j, ry, rm, rd, doy;
    bit                lp;
    res = '0;
    y   = req.year_in;
    m   = req.month_in;
    d   = req.day_in;
    jn  = req.day_number_in;
    if (req.action == gjd_pkg::ACT_TO_JDN) begin
      if (y < gjd_pkg::YEAR_LOW) y = y + gjd_pkg::YEAR_OFS;
      if (y > gjd_pkg::YEAR_MAX || d == 0 || m < 1 || m > gjd_pkg::MONTH_DEC) return res;
      lim = mon_days[m - 1];
      if (m == gjd_pkg::MONTH_FEB && leap_year_of(y)) lim = lim + 1;
      if (d > lim) return res;
      yy = y;
      if (m > gjd_pkg::MONTH_FEB) begin
        mm = m - 3;
      end else begin
        mm = m + 9;
        yy = yy - 1;
      end
      c  = yy / 100;
      ya = yy - 100 * c;
      j  = (146097 * c) / 4 + (1461 * ya) / 4 + (153 * mm + 2) / 5 + d +
           gjd_pkg::JDN_BASE;
      if (j < gjd_pkg::JDN_MIN || j > gjd_pkg::JDN_MAX) return res;
      jdn_to_civil(j, ry, rm, rd);
      if (ry != y) return res;
      res.valid_res      = 1'b1;
      res.day_number_out = j[22:0];
      return res;
    end
    if (jn < gjd_pkg::JDN_MIN || jn > gjd_pkg::JDN_MAX) return res;
    jdn_to_civil(jn, ry, rm, rd);
    lp  = leap_year_of(ry);
    doy = mon_first[(rm - 1) % 12] + rd - 1;
    if (lp && rm > gjd_pkg::MONTH_FEB) doy = doy + 1;
    res.valid_res      = 1'b1;
    res.day_number_out = jn[22:0];
    res.year_out       = ry[13:0];
    res.month_out      = rm[3:0];
    res.day_out        = rd[4:0];
    res.weekday        = 3'(((jn % 7) + 1) % 7);
    res.day_of_year    = doy[8:0];
    res.leap_year      = lp;
    return res;
  endfunction

  function automatic gjd_pkg::gjd_in_t random_request();
    gjd_pkg::gjd_in_t r;
    int unsigned      kind, len, yr;
    r.action        = 1'($urandom());
    r.year_in       = 14'($urandom());
    r.month_in      = 4'($urandom());
    r.day_in        = 5'($urandom());
    r.day_number_in = 23'($urandom());
    kind = $urandom_range(99);
    if (kind < 45) begin
      r.action   = gjd_pkg::ACT_TO_JDN;
      r.year_in  = ($urandom_range(9) == 0) ? 14'($urandom_range(99))
                                             : 14'($urandom_range(9999, 100));
      r.month_in = 4'($urandom_range(12, 1));
      yr  = (r.year_in < gjd_pkg::YEAR_LOW) ? r.year_in + gjd_pkg::YEAR_OFS : r.year_in;
      len = mon_days[r.month_in - 1];
      if (r.month_in == gjd_pkg::MONTH_FEB && leap_year_of(yr)) len = len + 1;
      r.day_in = ($urandom_range(7) == 0) ? 5'(len + 1) : 5'($urandom_range(len, 1));
    end else if (kind < 80) begin
      r.action = gjd_pkg::ACT_TO_DATE;
      if ($urandom_range(19) == 0)
        r.day_number_in = 23'(($urandom_range(1) ? gjd_pkg::JDN_MIN : gjd_pkg::JDN_MAX) +
                              $urandom_range(4) - 2);
      else
        r.day_number_in = 23'($urandom_range(gjd_pkg::JDN_MAX, gjd_pkg::JDN_MIN));
    end
    return r;
  endfunction

  task automatic queue_request(logic act, int unsigned y, int unsigned m, int unsigned d,
                               int unsigned jn);
    gjd_pkg::gjd_in_t r;
    r.action        = act;
    r.year_in       = 14'(y);
    r.month_in      = 4'(m);
    r.day_in        = 5'(d);
    r.day_number_in = 23'(jn);
    pend_q.push_back(r);
  endtask

  task automatic flag_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= src_idle) begin
        in_if.valid <= 1'b1;
        in_if.data  <= pend_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  // monitor: predict on request transfer, check on result transfer
  always @(posedge clk_i) begin
    gjd_pkg::gjd_res_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) exp_q.push_back(predict_conversion(in_if.data));
      if (out_if.valid && out_if.ready) begin
        if (exp_q.size() == 0) begin
          flag_mismatch("result transfer with no pending request");
        end else begin
          want = exp_q.pop_front();
          check_field("valid_res", out_if.data.valid_res, want.valid_res);
          check_field("day_number_out", out_if.data.day_number_out, want.day_number_out);
          check_field("year_out", out_if.data.year_out, want.year_out);
          check_field("month_out", out_if.data.month_out, want.month_out);
          check_field("day_out", out_if.data.day_out, want.day_out);
          check_field("weekday", out_if.data.weekday, want.weekday);
          check_field("day_of_year", out_if.data.day_of_year, want.day_of_year);
          check_field("leap_year", out_if.data.leap_year, want.leap_year);
        end
      end
    end
  end

  initial begin
    int src_pct [4];
    int snk_pct [4];
    src_pct = '{0, 46, 0, 10};
    snk_pct = '{0, 0, 46, 10};
    rst_ni  = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    queue_request(gjd_pkg::ACT_TO_JDN, 0, 1, 1, 0);
    queue_request(gjd_pkg::ACT_TO_JDN, 99, 12, 31, 8388607);
    queue_request(gjd_pkg::ACT_TO_JDN, 100, 1, 1, 0);
    queue_request(gjd_pkg::ACT_TO_JDN, 9999, 12, 31, 0);
    queue_request(gjd_pkg::ACT_TO_JDN, 10000, 1, 1, 0);
    queue_request(gjd_pkg::ACT_TO_JDN, 16383, 15, 31, 8388607);
    queue_request(gjd_pkg::ACT_TO_JDN, 2000, 0, 10, 0);
    queue_request(gjd_pkg::ACT_TO_JDN, 2000, 13, 1, 0);
    queue_request(gjd_pkg::ACT_TO_JDN, 2000, 5, 0, 0);
    queue_request(gjd_pkg::ACT_TO_JDN, 2001, 4, 31, 0);
    queue_request(gjd_pkg::ACT_TO_JDN, 2000, 2, 29, 0);
    queue_request(gjd_pkg::ACT_TO_JDN, 0, 2, 29, 0);
    queue_request(gjd_pkg::ACT_TO_JDN, 2100, 2, 29, 0);
    queue_request(gjd_pkg::ACT_TO_JDN, 2004, 2, 29, 0);
    queue_request(gjd_pkg::ACT_TO_JDN, 1600, 3, 1, 0);
    queue_request(gjd_pkg::ACT_TO_DATE, 0, 0, 0, gjd_pkg::JDN_MIN - 1);
    queue_request(gjd_pkg::ACT_TO_DATE, 16383, 15, 31, gjd_pkg::JDN_MIN);
    queue_request(gjd_pkg::ACT_TO_DATE, 0, 0, 0, gjd_pkg::JDN_MAX);
    queue_request(gjd_pkg::ACT_TO_DATE, 0, 0, 0, gjd_pkg::JDN_MAX + 1);
    queue_request(gjd_pkg::ACT_TO_DATE, 0, 0, 0, 0);
    queue_request(gjd_pkg::ACT_TO_DATE, 0, 0, 0, 8388607);
    queue_request(gjd_pkg::ACT_TO_DATE, 0, 0, 0, 2451545);
    queue_request(gjd_pkg::ACT_TO_DATE, 0, 0, 0, 2451605);
    queue_request(gjd_pkg::ACT_TO_DATE, 0, 0, 0, 2415020);

    for (int p = 0; p < 4; p++) begin
      src_idle  = src_pct[p];
      snk_stall = snk_pct[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) pend_q.push_back(random_request());
      // hold off new requests until every result is back
      while (pend_q.size() != 0 || in_if.valid || exp_q.size() != 0) @(negedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: gregorian_julian_day_converter_top.f
+incdir+sv
sv/gjd_pkg.sv
sv/gjd_if.sv
sv/gregorian_julian_day_converter_top.sv
verif/testbench.sv
